FILE: sv/gpfc_pkg.sv
// ----------------------------------------------------------------------------
// gpfc_pkg
// shared types and codes for the gif palette frame compositor
// ----------------------------------------------------------------------------
package gpfc_pkg;

   // command codes carried in tuser of the request channel
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_PIXEL = 2'd1;
   localparam logic [1:0] CMD_FRAME = 2'd2;

   // result status codes
   localparam logic [2:0] ST_WRITTEN     = 3'd0;
   localparam logic [2:0] ST_TRANSPARENT = 3'd1;
   localparam logic [2:0] ST_ERROR       = 3'd2;
   localparam logic [2:0] ST_ABORTED     = 3'd3;
   localparam logic [2:0] ST_DONE        = 3'd4;

   // configuration register indexes
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_FRAME_LEFT    = 3'd2;
   localparam logic [2:0] REG_FRAME_TOP     = 3'd3;
   localparam logic [2:0] REG_COLOR_COUNT   = 3'd4;
   localparam logic [2:0] REG_TRANS_ENABLE  = 3'd5;
   localparam logic [2:0] REG_TRANS_INDEX   = 3'd6;

   typedef struct packed {
      logic [15:0] screen_width;
      logic [15:0] screen_height;
      logic [15:0] frame_left;
      logic [15:0] frame_top;
      logic [8:0]  color_count;
      logic        transparent_enable;
      logic [7:0]  transparent_index;
   } cfg_type;

   // classified word between the front stage and the output stage
   typedef struct packed {
      logic        valid;
      logic        write_enable;
      logic [2:0]  status;
      logic [15:0] canvas_x;
      logic [15:0] canvas_y;
   } stage_type;

endpackage

FILE: sv/gpfc_palette_ram.sv
// ----------------------------------------------------------------------------
// gpfc_palette_ram
// palette memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module gpfc_palette_ram
   import gpfc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256,
   localparam int AW = $clog2(PALETTE_ENTRIES)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [23:0]   rd_data_ff
);

   logic [23:0] mem [PALETTE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: sv/gpfc_front.sv
// ----------------------------------------------------------------------------
// gpfc_front
// classifies each accepted word, keeps the sticky abort flag, drives the
// palette write enable and the shared palette address
// ----------------------------------------------------------------------------
module gpfc_front
   import gpfc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256,
   localparam int AW = $clog2(PALETTE_ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          accept,
   input  logic          load_en,
   input  logic [1:0]    cmd,
   input  logic [7:0]    color_index,
   input  logic [15:0]   frame_x,
   input  logic [15:0]   frame_y,
   output logic          ram_wr_en,
   output logic [AW-1:0] ram_addr,
   output stage_type     stage_ff
);

   logic      abort_ff, abort_in;
   stage_type stage_in;
   logic [16:0] tx, ty;
   logic        idx_in_pal, bad_pixel;

   assign tx = {1'b0, cfg.frame_left} + {1'b0, frame_x};
   assign ty = {1'b0, cfg.frame_top} + {1'b0, frame_y};
   assign idx_in_pal = {1'b0, color_index} < 9'(PALETTE_ENTRIES);
   assign bad_pixel = ({1'b0, color_index} >= cfg.color_count) || !idx_in_pal
                      || (tx >= {1'b0, cfg.screen_width})
                      || (ty >= {1'b0, cfg.screen_height});

   assign ram_addr  = color_index[AW-1:0];
   assign ram_wr_en = accept && (cmd == CMD_LOAD) && idx_in_pal;

   always_comb begin
      abort_in = abort_ff;
      stage_in = stage_ff;
      if (load_en) begin
         stage_in.valid        = accept;
         stage_in.write_enable = 1'b0;
         stage_in.status       = ST_DONE;
         stage_in.canvas_x     = tx[15:0];
         stage_in.canvas_y     = ty[15:0];
         if (accept) begin
            case (cmd)
               CMD_FRAME: abort_in = 1'b0;
               CMD_PIXEL: begin
                  if (abort_ff) begin
                     stage_in.status = ST_ABORTED;
                  end else if (cfg.color_count == 9'd0) begin
                     stage_in.status = ST_ERROR;
                     abort_in = 1'b1;
                  end else if (cfg.transparent_enable &&
                               color_index == cfg.transparent_index) begin
                     stage_in.status = ST_TRANSPARENT;
                  end else if (bad_pixel) begin
                     stage_in.status = ST_ERROR;
                     abort_in = 1'b1;
                  end else begin
                     stage_in.status       = ST_WRITTEN;
                     stage_in.write_enable = 1'b1;
                  end
               end
               default: abort_in = abort_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abort_ff <= 1'b0;
         stage_ff <= '0;
      end else begin
         abort_ff <= abort_in;
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: sv/gif_palette_frame_compositor.sv
// ----------------------------------------------------------------------------
// gif_palette_frame_compositor
// composites a gif sub-image onto an rgb canvas through a palette memory
// ----------------------------------------------------------------------------
//
//  channel  direction  payload
//  req_     in         tuser: cmd; tdata: index, rgb, frame x, frame y
//  rsp_     out        tuser: write enable, status; tdata: address, r, g, b
//  csr_     in         write enable, register index, 16-bit write data
//
//  one word per clock sustained while the output is taken; each word passes
//  classify plus palette read, then the row times width multiply
//  reset is synchronous and active high, the palette is not cleared
//  a stalled output holds the pipe; input stays ready while stage one is
//  empty or moving
//
module gif_palette_frame_compositor
   import gpfc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // color_index, rgb_value, frame_x, frame_y
   input  logic [1:0]  req_tuser,  // cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // pixel_address, red, green, blue
   output logic [3:0]  rsp_tuser,  // write_enable, status
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(PALETTE_ENTRIES);

   cfg_type cfg_ff, cfg_in;

   // configuration registers, index beyond the list falls through
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_SCREEN_WIDTH:  cfg_in.screen_width       = csr_wdata;
            REG_SCREEN_HEIGHT: cfg_in.screen_height      = csr_wdata;
            REG_FRAME_LEFT:    cfg_in.frame_left         = csr_wdata;
            REG_FRAME_TOP:     cfg_in.frame_top          = csr_wdata;
            REG_COLOR_COUNT:   cfg_in.color_count        = csr_wdata[8:0];
            REG_TRANS_ENABLE:  cfg_in.transparent_enable = csr_wdata[0];
            REG_TRANS_INDEX:   cfg_in.transparent_index  = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{screen_width: 16'd1, screen_height: 16'd1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control: output register advances when empty or taken
   logic      out_valid_ff;
   logic      advance;
   logic      accept;
   stage_type stage;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !stage.valid || advance;
   assign accept     = req_tvalid && req_tready;

   logic          ram_wr_en;
   logic [AW-1:0] ram_addr;
   logic [23:0]   ram_rd_data;

   gpfc_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .load_en     (req_tready),
      .cmd         (req_tuser),
      .color_index (req_tdata[7:0]),
      .frame_x     (req_tdata[47:32]),
      .frame_y     (req_tdata[63:48]),
      .ram_wr_en   (ram_wr_en),
      .ram_addr    (ram_addr),
      .stage_ff    (stage)
   );

   // palette read rides along with the accept, data is ready in stage one
   gpfc_palette_ram #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_palette (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_addr),
      .wr_data    (req_tdata[31:8]),
      .rd_en      (accept),
      .rd_addr    (ram_addr),
      .rd_data_ff (ram_rd_data)
   );

   // stage two: canvas address, zeroed unless the pixel is written
   logic [31:0] addr_calc;
   logic [55:0] data_ff, data_in;
   logic [3:0]  user_ff, user_in;

   assign addr_calc = (32'(stage.canvas_y) * 32'(cfg_ff.screen_width))
                      + 32'(stage.canvas_x);

   always_comb begin
      data_in = data_ff;
      user_in = user_ff;
      if (advance) begin
         data_in = stage.write_enable ? {ram_rd_data[7:0], ram_rd_data[15:8],
                                         ram_rd_data[23:16], addr_calc}
                                      : 56'd0;
         user_in = {stage.status, stage.write_enable};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

FILE: test/gpfc_canvas_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpfc_canvas_checker
// watches the request, result and register ports of the compositor, predicts
// each canvas result from its own copy of the palette, abort flag and
// registers, and compares every result word field by field in order
// ----------------------------------------------------------------------------
module gpfc_canvas_checker
   import gpfc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,  // color_index, rgb_value, frame_x, frame_y
   input  logic [1:0]  req_tuser,  // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,  // pixel_address, red, green, blue
   input  logic [3:0]  rsp_tuser,  // write_enable, status
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          pending_words,
   output int          write_count
);

   typedef struct packed {
      logic        write_enable;
      logic [31:0] pixel_address;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [2:0]  status;
   } canvas_result_type;

   canvas_result_type expected_pixels[$];

   logic [15:0] screen_width, screen_height, frame_left, frame_top;
   logic [8:0]  color_count;
   logic        trans_enable;
   logic [7:0]  trans_index;
   logic [23:0] palette [PALETTE_ENTRIES];
   logic        aborted;

   function automatic canvas_result_type composite_word(input logic [1:0] cmd,
         input logic [7:0] idx, input logic [23:0] rgb,
         input logic [15:0] fx, input logic [15:0] fy);
      canvas_result_type r;
      logic [16:0]    cx, cy;
      logic [63:0]    addr;
      r = '0;
      r.status = ST_DONE;
      cx = {1'b0, frame_left} + {1'b0, fx};
      cy = {1'b0, frame_top} + {1'b0, fy};
      case (cmd)
         CMD_LOAD: begin
            if (idx < PALETTE_ENTRIES) palette[idx] = rgb;
         end
         CMD_FRAME: begin
            aborted = 1'b0;
         end
         CMD_PIXEL: begin
            if (aborted) begin
               r.status = ST_ABORTED;
            end else if (color_count == 0) begin
               aborted = 1'b1;
               r.status = ST_ERROR;
            end else if (trans_enable && idx == trans_index) begin
               r.status = ST_TRANSPARENT;
            end else if (idx >= color_count || idx >= PALETTE_ENTRIES ||
                         cx >= screen_width || cy >= screen_height) begin
               aborted = 1'b1;
               r.status = ST_ERROR;
            end else begin
               addr = 64'(cy) * 64'(screen_width) + 64'(cx);
               r.write_enable = 1'b1;
               r.pixel_address = addr[31:0];
               {r.red, r.green, r.blue} = palette[idx];
               r.status = ST_WRITTEN;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      canvas_result_type want;
      if (reset) begin
         expected_pixels.delete();
         screen_width  = 16'd1;
         screen_height = 16'd1;
         frame_left    = '0;
         frame_top     = '0;
         color_count   = '0;
         trans_enable  = 1'b0;
         trans_index   = '0;
         aborted       = 1'b0;
         mismatches    = 0;
         pending_words = 0;
         write_count   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               $display("%0t: result word expected none actual %h/%h", $time,
                        rsp_tuser, rsp_tdata);
            end else begin
               want = expected_pixels.pop_front();
               check_field("write_enable", 32'(want.write_enable), 32'(rsp_tuser[0]));
               check_field("status", 32'(want.status), 32'(rsp_tuser[3:1]));
               check_field("pixel_address", want.pixel_address, rsp_tdata[31:0]);
               check_field("red", 32'(want.red), 32'(rsp_tdata[39:32]));
               check_field("green", 32'(want.green), 32'(rsp_tdata[47:40]));
               check_field("blue", 32'(want.blue), 32'(rsp_tdata[55:48]));
               if (want.write_enable) write_count++;
            end
         end
         if (req_tvalid && req_tready)
            expected_pixels.push_back(composite_word(req_tuser, req_tdata[7:0],
               req_tdata[31:8], req_tdata[47:32], req_tdata[63:48]));
         if (csr_we) begin
            case (csr_index)
               REG_SCREEN_WIDTH:  screen_width  = csr_wdata;
               REG_SCREEN_HEIGHT: screen_height = csr_wdata;
               REG_FRAME_LEFT:    frame_left    = csr_wdata;
               REG_FRAME_TOP:     frame_top     = csr_wdata;
               REG_COLOR_COUNT:   color_count   = csr_wdata[8:0];
               REG_TRANS_ENABLE:  trans_enable  = csr_wdata[0];
               REG_TRANS_INDEX:   trans_index   = csr_wdata[7:0];
               default: ;
            endcase
         end
         pending_words = expected_pixels.size();
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives the gif palette frame compositor with a directed opening and then
// random frames of palette loads, pixels and frame starts under several
// register settings, with random idling on both channels; a checker module
// beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;
   import gpfc_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;  // no-op command code
   localparam logic [2:0] REG_UNUSED  = 3'd7;  // index past the register list
   localparam int         NUM_PHASES  = 8;
   localparam int         PHASE_WORDS = 130;
   localparam int         CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // color_index, rgb_value, frame_x, frame_y
   logic [1:0]  req_tuser = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // pixel_address, red, green, blue
   logic [3:0]  rsp_tuser;        // write_enable, status
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int mismatches, pending_words, write_count;
   int words_sent = 0;
   int cycle_count = 0;
   bit sender_burst = 0;

   // register values as last written, so stimulus can aim pixels on canvas
   int cfg_w, cfg_h, cfg_l, cfg_t, cfg_cc, cfg_te, cfg_ti;
   // palette entries loaded so far; the block's palette is not cleared by
   // reset, so no pixel may ever read an entry that was never loaded
   bit loaded [256];

   gif_palette_frame_compositor i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   gpfc_canvas_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending_words (pending_words),
      .write_count   (write_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // watchdog: the slowest legal run stays far below this
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout with %0d words outstanding", $time, pending_words);
      $display("gif_palette_frame_compositor: mismatch");
      $finish;
   end

   // mostly short pauses, now and then a long one
   function automatic int pause_cycles();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one request word: optional idle gap, then hold valid until accepted;
   // called at a falling edge and returns at a falling edge
   task automatic offer_word(input logic [1:0] cmd, input logic [7:0] idx,
         input logic [23:0] rgb, input logic [15:0] fx, input logic [15:0] fy);
      int gap;
      gap = (sender_burst || $urandom_range(0, 99) < 60) ? 0 : pause_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {fy, fx, rgb, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic load_entry(input logic [7:0] idx, input logic [23:0] rgb);
      offer_word(CMD_LOAD, idx, rgb, 16'($urandom), 16'($urandom));
      loaded[idx] = 1'b1;
   endtask

   task automatic pixel(input logic [7:0] idx, input logic [15:0] fx,
         input logic [15:0] fy);
      offer_word(CMD_PIXEL, idx, 24'($urandom), fx, fy);
   endtask

   task automatic frame_start();
      offer_word(CMD_FRAME, 8'($urandom), 24'($urandom), 16'($urandom),
                 16'($urandom));
   endtask

   // registers change only with the block idle: every result back first;
   // csr_we stays high across the burst and drops once at the end
   task automatic reconfigure(input int w, input int h, input int l, input int t,
         input int cc, input int te, input int ti, input bit poke_unused);
      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      cfg_w = w; cfg_h = h; cfg_l = l; cfg_t = t;
      cfg_cc = cc; cfg_te = te; cfg_ti = ti;
      csr_we <= 1'b1;
      csr_index <= REG_SCREEN_WIDTH;  csr_wdata <= 16'(w);  @(negedge clock);
      csr_index <= REG_SCREEN_HEIGHT; csr_wdata <= 16'(h);  @(negedge clock);
      csr_index <= REG_FRAME_LEFT;    csr_wdata <= 16'(l);  @(negedge clock);
      csr_index <= REG_FRAME_TOP;     csr_wdata <= 16'(t);  @(negedge clock);
      csr_index <= REG_COLOR_COUNT;   csr_wdata <= 16'(cc); @(negedge clock);
      csr_index <= REG_TRANS_ENABLE;  csr_wdata <= 16'(te); @(negedge clock);
      csr_index <= REG_TRANS_INDEX;   csr_wdata <= 16'(ti); @(negedge clock);
      if (poke_unused) begin
         // write past the list, must leave every register alone
         csr_index <= REG_UNUSED; csr_wdata <= 16'hffff; @(negedge clock);
      end
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // register setting for each random phase, extremes among them
   task automatic pick_setting(input int p);
      int w, h;
      case (p)
         0: reconfigure(64, 48, 0, 0, 16, 1, 3, 0);
         1: reconfigure(1, 1, 0, 0, 256, 0, 0, 0);
         2: reconfigure(65535, 65535, 65000, 65500, 256, 1, 255, 0);
         3: reconfigure(320, 200, 300, 190, 2, 1, 1, 0);
         4: reconfigure(100, 7, 0, 0, 0, 0, 0, 1);   // no palette at all
         7: reconfigure(65535, 1, 0, 0, 128, 1, 200, 0);
         default: begin
            w = $urandom_range(1, 400);
            h = $urandom_range(1, 300);
            reconfigure(w, h, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                        $urandom_range(1, 256), $urandom_range(0, 1),
                        $urandom_range(0, 255), 0);
         end
      endcase
   endtask

   // mostly on-canvas pixels with in-range indexes, plus loads, frame starts,
   // the unused command and the odd bad index or off-canvas position
   task automatic random_word();
      int          pick;
      logic [7:0]  idx;
      logic [15:0] fx, fy;
      pick = $urandom_range(0, 99);
      idx  = 8'($urandom);
      fx   = 16'($urandom);
      fy   = 16'($urandom);
      if (pick < 6) begin
         frame_start();
      end else if (pick < 8) begin
         offer_word(CMD_UNUSED, idx, 24'($urandom), fx, fy);
      end else if (pick < 20) begin
         load_entry(idx, 24'($urandom));
      end else begin
         if (cfg_l < cfg_w && $urandom_range(0, 19) != 0)
            fx = 16'($urandom_range(0, cfg_w - 1 - cfg_l));
         if (cfg_t < cfg_h && $urandom_range(0, 19) != 0)
            fy = 16'($urandom_range(0, cfg_h - 1 - cfg_t));
         pick = $urandom_range(0, 19);
         if (pick == 1)
            idx = 8'(cfg_ti);
         else if (pick != 0 && cfg_cc > 0)
            idx = 8'($urandom_range(0, cfg_cc - 1));
         // a pixel that could read a never-loaded entry becomes its load
         if (idx < cfg_cc && !(cfg_te != 0 && idx == cfg_ti) && !loaded[idx])
            load_entry(idx, 24'($urandom));
         else
            pixel(idx, fx, fy);
      end
   endtask

   // result side: random stalls in changing density, plus one long hold-off
   // while the sender keeps offering so the pipe fills and backs up
   initial begin : rsp_side
      int hold;
      int stall_pct;
      bit held_off;
      hold = 0;
      stall_pct = 10;
      held_off = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (cycle_count % 256 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 10;
               default: stall_pct = 35;
            endcase
         end
         if (!held_off && words_sent >= 200) begin
            held_off = 1;
            hold = 300;
         end else if (hold == 0 && $urandom_range(0, 99) < stall_pct) begin
            hold = pause_cycles();
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   initial begin
      foreach (loaded[i]) loaded[i] = 1'b0;
      cfg_w = 1; cfg_h = 1; cfg_l = 0; cfg_t = 0;
      cfg_cc = 0; cfg_te = 0; cfg_ti = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed opening ---
      // reset registers: unused command, then a pixel with no palette
      offer_word(CMD_UNUSED, 8'hff, 24'hffffff, 16'hffff, 16'hffff);
      pixel(8'd0, 16'd0, 16'd0);                 // no palette: error, abort
      pixel(8'd0, 16'd0, 16'd0);                 // aborted skip
      load_entry(8'd0, 24'hffffff);              // load goes through while aborted
      load_entry(8'd255, 24'h000000);
      frame_start();

      // widest canvas, full palette, top entry transparent
      reconfigure(65535, 65535, 0, 0, 256, 1, 255, 0);
      pixel(8'd255, 16'd0, 16'd0);               // transparent
      pixel(8'd0, 16'd65534, 16'd65534);         // highest address
      pixel(8'd0, 16'd0, 16'd0);                 // address zero
      pixel(8'd0, 16'd65535, 16'd0);             // column off canvas
      pixel(8'd255, 16'd0, 16'd0);               // transparent while aborted
      frame_start();

      // small canvas with offsets; transparency is tested before range
      reconfigure(16, 8, 10, 3, 1, 1, 7, 0);
      pixel(8'd7, 16'd0, 16'd0);                 // out of range but transparent
      pixel(8'd1, 16'd0, 16'd0);                 // index past color count
      frame_start();
      pixel(8'd0, 16'd5, 16'd4);                 // last column and row
      pixel(8'd0, 16'd65535, 16'd65535);         // far off canvas
      frame_start();

      // zero width: every pixel is an error
      reconfigure(0, 65535, 0, 0, 256, 0, 0, 0);
      pixel(8'd0, 16'd0, 16'd0);
      frame_start();

      // unit canvas, then a write past the register list that changes nothing
      reconfigure(1, 1, 0, 0, 1, 0, 0, 1);
      pixel(8'd0, 16'd0, 16'd0);

      // --- random phases ---
      for (int p = 0; p < NUM_PHASES; p++) begin
         pick_setting(p);
         sender_burst = (p % 3 == 1);
         frame_start();
         repeat (PHASE_WORDS) random_word();
      end

      // drain, then let the pipe settle
      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d request words: directed corner cases and %0d register settings",
               words_sent, NUM_PHASES);
      $display("%0d canvas writes among the checked results, with long output stalls",
               write_count);
      if (mismatches == 0 && pending_words == 0) begin
         $display("gif_palette_frame_compositor: match");
      end else begin
         $display("gif_palette_frame_compositor: mismatch");
      end
      $finish;
   end

endmodule
